@@ hw/rtl/gbc_pkg.sv @@
// Package for the grid broad-phase collision engine: sizes, types and codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gbc_pkg;
    localparam int CELL_SIZE     = 32;
    localparam int GRID_COLS     = 32;
    localparam int GRID_ROWS     = 32;
    localparam int CELL_CAPACITY = 8;
    localparam int ID_BITS       = 8;
    localparam int NUM_CELLS     = GRID_COLS * GRID_ROWS;
    localparam int CELL_BITS     = $clog2(NUM_CELLS);
    localparam int SLOT_BITS     = $clog2(CELL_CAPACITY);
    localparam int FILL_BITS     = $clog2(CELL_CAPACITY + 1);
    localparam int COL_BITS      = $clog2(GRID_COLS);
    localparam int ROW_BITS      = $clog2(GRID_ROWS);
    localparam int SHIFT         = $clog2(CELL_SIZE);
    localparam int ENTRY_BITS    = 10 + 10 + 8 + 8 + ID_BITS;

    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef struct packed {
        logic [9:0]         x;
        logic [9:0]         y;
        logic [7:0]         w;
        logic [7:0]         h;
        logic [ID_BITS-1:0] id;
    } t_box;

    typedef struct packed {
        logic       op;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        logic [7:0] width;
        logic [7:0] height;
        logic [7:0] object_id;
    } t_request;

    typedef struct packed {
        logic       pair_valid;
        logic [7:0] new_id;
        logic [7:0] stored_id;
        logic       cell_full;
        logic       last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WIPE, ST_FILL, ST_FILLW, ST_READ, ST_CMP,
        ST_STORE, ST_STOREW, ST_STATUS, ST_EMIT
    } t_state;

    // Overlap test on centres: |dx|*2 < wa+wb and |dy|*2 < ha+hb.
    function automatic logic boxes_hit(t_box a, t_box b);
        logic [9:0] dx;
        logic [9:0] dy;
        dx = (a.x >= b.x) ? a.x - b.x : b.x - a.x;
        dy = (a.y >= b.y) ? a.y - b.y : b.y - a.y;
        return ({1'b0, dx} << 1) < {2'b00, {1'b0, a.w} + {1'b0, b.w}} &&
               ({1'b0, dy} << 1) < {2'b00, {1'b0, a.h} + {1'b0, b.h}};
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/gbc_stream_if.sv @@
// Valid/ready stream interface carrying one payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface gbc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/gbc_fill_mem.sv @@
// Per-cell fill count memory with a registered read.
// Depends on gbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbc_fill_mem
    import gbc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [CELL_BITS-1:0] i_waddr,
    input  wire logic [FILL_BITS-1:0] i_wdata,
    input  wire logic [CELL_BITS-1:0] i_raddr,
    output logic      [FILL_BITS-1:0] o_rdata
);
    logic [FILL_BITS-1:0] r_mem [NUM_CELLS];

    // One write port and one read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/gbc_entry_mem.sv @@
// Slot memory that holds the boxes stored in each cell.
// Depends on gbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbc_entry_mem
    import gbc_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [CELL_BITS+SLOT_BITS-1:0] i_waddr,
    input  wire t_box                           i_wdata,
    input  wire logic [CELL_BITS+SLOT_BITS-1:0] i_raddr,
    output t_box                                o_rdata
);
    t_box r_mem [NUM_CELLS*CELL_CAPACITY];

    // One write port and one read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/grid_broadphase_aabb_collision.sv @@
// Grid broad-phase collision engine, top level.
// A clear request runs a wiping pass over every cell, then returns a status result; an insert
// reads the fill count of each covered cell, then reads and compares its stored slots one at
// a time, then stores the box in each cell that has room and returns a status result.
// One request is worked on at a time; the result register frees the input.
// Reset clears control state and runs a wiping pass over every cell with no result.
`timescale 1ns / 1ps
`default_nettype none
module grid_broadphase_aabb_collision
    import gbc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [5:0] i_cfg_data,
    gbc_stream_if.sink      s_req,
    gbc_stream_if.source    m_res
);
    t_state r_state, n_state;
    logic [5:0] r_cols, r_rows;
    t_box r_box;
    logic [CELL_BITS-1:0] r_cells [4];
    logic [2:0] r_ncell;
    logic [1:0] r_ci;
    logic [CELL_BITS-1:0] r_wipe;
    logic [FILL_BITS-1:0] r_n;
    logic [SLOT_BITS:0] r_j;
    logic r_full;
    logic r_ov;
    logic r_boot;
    t_result r_out;

    logic fill_we;
    logic [CELL_BITS-1:0] fill_waddr;
    logic [FILL_BITS-1:0] fill_wdata;
    logic [FILL_BITS-1:0] fill_rd;
    logic [FILL_BITS-1:0] fill_cnt;
    logic ent_we;
    logic [CELL_BITS+SLOT_BITS-1:0] ent_raddr;
    logic [CELL_BITS+SLOT_BITS-1:0] ent_waddr;
    t_box ent_rd;

    logic [CELL_BITS-1:0] cur_cell;
    assign cur_cell = r_cells[r_ci];

    gbc_fill_mem u_fill (
        .i_clk  (i_clk),
        .i_we   (fill_we),
        .i_waddr(fill_waddr),
        .i_wdata(fill_wdata),
        .i_raddr(cur_cell),
        .o_rdata(fill_rd)
    );

    gbc_entry_mem u_entry (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(ent_waddr),
        .i_wdata(r_box),
        .i_raddr(ent_raddr),
        .o_rdata(ent_rd)
    );

    // Fill count of the cell addressed in the previous cycle, limited to the capacity.
    assign fill_cnt = (fill_rd > FILL_BITS'(CELL_CAPACITY))
                    ? FILL_BITS'(CELL_CAPACITY) : fill_rd;

    assign ent_raddr = {cur_cell, r_j[SLOT_BITS-1:0]};
    assign ent_waddr = {cur_cell, fill_cnt[SLOT_BITS-1:0]};

    // Cell mapping of a new request, with clamping to the grid in use.
    logic [5:0] cols_c, rows_c;
    logic [10:0] xr, yb;
    logic [COL_BITS-1:0] cl, cr;
    logic [ROW_BITS-1:0] rt, rb;
    always_comb begin
        logic [10:0] lq, rq, tq, bq;
        cols_c = (r_cols == 6'd0) ? 6'd1 : (r_cols > 6'(GRID_COLS)) ? 6'(GRID_COLS) : r_cols;
        rows_c = (r_rows == 6'd0) ? 6'd1 : (r_rows > 6'(GRID_ROWS)) ? 6'(GRID_ROWS) : r_rows;
        xr = {1'b0, s_req.data.pos_x} + {3'b0, s_req.data.width};
        yb = {1'b0, s_req.data.pos_y} + {3'b0, s_req.data.height};
        lq = {1'b0, s_req.data.pos_x} >> SHIFT;
        rq = xr >> SHIFT;
        tq = {1'b0, s_req.data.pos_y} >> SHIFT;
        bq = yb >> SHIFT;
        cl = (lq > 11'(cols_c - 6'd1)) ? COL_BITS'(cols_c - 6'd1) : COL_BITS'(lq);
        cr = (rq > 11'(cols_c - 6'd1)) ? COL_BITS'(cols_c - 6'd1) : COL_BITS'(rq);
        rt = (tq > 11'(rows_c - 6'd1)) ? ROW_BITS'(rows_c - 6'd1) : ROW_BITS'(tq);
        rb = (bq > 11'(rows_c - 6'd1)) ? ROW_BITS'(rows_c - 6'd1) : ROW_BITS'(bq);
    end

    logic req_fire, res_fire;
    assign req_fire = s_req.valid && s_req.ready;
    assign res_fire = m_res.valid && m_res.ready;
    assign s_req.ready = (r_state == ST_IDLE);
    assign m_res.valid = r_ov;
    assign m_res.data  = r_out;

    logic hit;
    assign hit = (ent_rd.id != r_box.id) && boxes_hit(r_box, ent_rd);

    // Next state and memory writes.
    always_comb begin
        n_state    = r_state;
        fill_we    = 1'b0;
        fill_waddr = cur_cell;
        fill_wdata = fill_cnt + FILL_BITS'(1);
        ent_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_state = (s_req.data.op == OP_CLEAR) ? ST_WIPE : ST_FILL;
                end
            end
            ST_WIPE: begin
                fill_we    = 1'b1;
                fill_waddr = r_wipe;
                fill_wdata = '0;
                if (r_wipe == CELL_BITS'(NUM_CELLS - 1)) begin
                    n_state = r_boot ? ST_IDLE : ST_STATUS;
                end
            end
            ST_FILL:  n_state = ST_FILLW;
            ST_FILLW: n_state = ST_READ;
            ST_READ: begin
                if (r_j >= {1'b0, r_n[SLOT_BITS-1:0]} && r_n < FILL_BITS'(CELL_CAPACITY)
                    || r_j == (SLOT_BITS+1)'(CELL_CAPACITY)) begin
                    if (r_ci == 2'(r_ncell - 3'd1)) begin
                        n_state = ST_STORE;
                    end else begin
                        n_state = ST_FILL;
                    end
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!(hit && r_ov && !m_res.ready)) begin
                    n_state = ST_READ;
                end
            end
            ST_STORE:  n_state = ST_STOREW;
            ST_STOREW: begin
                if (fill_cnt < FILL_BITS'(CELL_CAPACITY)) begin
                    fill_we = 1'b1;
                    ent_we  = 1'b1;
                end
                n_state = (r_ci == 2'(r_ncell - 3'd1)) ? ST_STATUS : ST_STORE;
            end
            ST_STATUS: begin
                if (!r_ov || m_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 6'd32;
            r_rows <= 6'd32;
            r_wipe <= '0;
            r_ov   <= 1'b0;
            r_ci   <= '0;
            r_j    <= '0;
            r_full <= 1'b0;
            r_boot <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_COLS) r_cols <= i_cfg_data;
                else r_rows <= i_cfg_data;
            end
            if (res_fire) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (req_fire) begin
                        r_box <= '{x: s_req.data.pos_x, y: s_req.data.pos_y,
                                   w: s_req.data.width, h: s_req.data.height,
                                   id: (s_req.data.op == OP_CLEAR) ? ID_BITS'(0)
                                                                   : s_req.data.object_id};
                        r_wipe <= '0;
                        r_ci <= '0;
                        r_j <= '0;
                        r_full <= 1'b0;
                        r_cells[0] <= {rt, cl};
                        r_cells[1] <= {rt, cr};
                        if (cr != cl) begin
                            r_cells[2] <= {rb, cl};
                            r_cells[3] <= {rb, cr};
                        end else begin
                            r_cells[1] <= {rb, cl};
                        end
                        r_ncell <= 3'd1 + ((cr != cl) ? 3'd1 : 3'd0)
                                 + ((rb != rt) ? ((cr != cl) ? 3'd2 : 3'd1) : 3'd0);
                    end
                end
                ST_WIPE: begin
                    r_wipe <= r_wipe + CELL_BITS'(1);
                    if (n_state != ST_WIPE) r_boot <= 1'b0;
                end
                ST_FILLW: begin
                    r_n <= fill_cnt;
                    r_j <= '0;
                end
                ST_READ: begin
                    if (n_state == ST_FILL || n_state == ST_STORE) begin
                        r_ci <= (n_state == ST_STORE) ? 2'd0 : r_ci + 2'd1;
                    end
                end
                ST_CMP: begin
                    if (n_state == ST_READ) begin
                        r_j <= r_j + (SLOT_BITS+1)'(1);
                        if (hit) begin
                            r_ov  <= 1'b1;
                            r_out <= '{pair_valid: 1'b1, new_id: r_box.id,
                                       stored_id: ent_rd.id, cell_full: 1'b0, last: 1'b0};
                        end
                    end
                end
                ST_STOREW: begin
                    if (fill_cnt >= FILL_BITS'(CELL_CAPACITY)) r_full <= 1'b1;
                    r_ci <= r_ci + 2'd1;
                end
                ST_STATUS: begin
                    if (n_state == ST_IDLE) begin
                        r_ov  <= 1'b1;
                        r_out <= '{pair_valid: 1'b0, new_id: r_box.id,
                                   stored_id: 8'd0, cell_full: r_full, last: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/gbc_checker.sv @@
// Port-level checks for the collision engine, bound to the top level.
// Depends on gbc_pkg and the stream interface.
`timescale 1ns / 1ps
`default_nettype none
module gbc_checker
    import gbc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    req_valid,
    input wire logic    req_ready,
    input wire logic    res_valid,
    input wire logic    res_ready,
    input wire t_result res_data
);
    // A pair result never closes a request.
    a_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_data.pair_valid |-> !res_data.last) else $error("pair marked last");
    // Pair results carry no full flag.
    a_pair_no_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_data.pair_valid |-> !res_data.cell_full) else $error("pair full");
    // Status results have no stored id.
    a_status_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_data.pair_valid |-> res_data.stored_id == 8'd0) else $error("status id");
    // After a request is taken no new one is taken the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready) else $error("request overlap");
endmodule

bind grid_broadphase_aabb_collision gbc_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .req_valid(s_req.valid),
    .req_ready(s_req.ready),
    .res_valid(m_res.valid),
    .res_ready(m_res.ready),
    .res_data (m_res.data)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the grid broad-phase collision engine.
// Depends on gbc_pkg, gbc_stream_if and the top level; drives requests, predicts pair and status results.
`timescale 1ns / 1ps
module tb_top;
    import gbc_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [5:0] i_cfg_data;

    gbc_stream_if #(.T(t_request)) req_if ();
    gbc_stream_if #(.T(t_result)) res_if ();

    grid_broadphase_aabb_collision dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .s_req(req_if.sink),
        .m_res(res_if.source)
    );

    // Clock with a period of 8 ns.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow of the grid held by the predictor.
    logic [3:0] grid_fill [NUM_CELLS];
    t_box grid_slots [NUM_CELLS][CELL_CAPACITY];
    logic [5:0] cols_reg;
    logic [5:0] rows_reg;

    t_request pending_reqs[$];
    t_result expected_results[$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned sent_count;
    bit req_taken;

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch: %s", what);
        mismatch_count++;
    endtask

    // Appends a request to the pending queue.
    task automatic queue_req(input t_request rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    // Appends a result to the expected queue.
    task automatic expect_result(input t_result rs);
        expected_results.insert(expected_results.size(), rs);
    endtask

    function automatic logic boxes_touch(t_box a, t_box b);
        int dx;
        int dy;
        dx = int'(a.x) - int'(b.x);
        dy = int'(a.y) - int'(b.y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx * 2 < int'(a.w) + int'(b.w)) && (dy * 2 < int'(a.h) + int'(b.h));
    endfunction

    function automatic t_result make_result(logic pv, logic [7:0] nid, logic [7:0] sid,
                                            logic full, logic fin);
        t_result r;
        r.pair_valid = pv;
        r.new_id = nid;
        r.stored_id = sid;
        r.cell_full = full;
        r.last = fin;
        return r;
    endfunction

    // Works out the results of one accepted request and updates the shadow grid.
    task automatic predict_collisions(input t_request rq);
        t_box nb;
        int cols;
        int rows;
        int l;
        int r;
        int t;
        int b;
        int cells[4];
        int ncell;
        logic full;
        if (rq.op == OP_CLEAR) begin
            foreach (grid_fill[c]) grid_fill[c] = '0;
            expect_result(make_result(1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
            return;
        end
        nb.x = rq.pos_x;
        nb.y = rq.pos_y;
        nb.w = rq.width;
        nb.h = rq.height;
        nb.id = rq.object_id;
        cols = (cols_reg == 0) ? 1 : (cols_reg > GRID_COLS ? GRID_COLS : int'(cols_reg));
        rows = (rows_reg == 0) ? 1 : (rows_reg > GRID_ROWS ? GRID_ROWS : int'(rows_reg));
        l = int'(nb.x) / CELL_SIZE;
        r = (int'(nb.x) + int'(nb.w)) / CELL_SIZE;
        t = int'(nb.y) / CELL_SIZE;
        b = (int'(nb.y) + int'(nb.h)) / CELL_SIZE;
        if (l > cols - 1) l = cols - 1;
        if (r > cols - 1) r = cols - 1;
        if (t > rows - 1) t = rows - 1;
        if (b > rows - 1) b = rows - 1;
        ncell = 0;
        cells[ncell++] = t * GRID_COLS + l;
        if (r != l) cells[ncell++] = t * GRID_COLS + r;
        if (b != t) begin
            cells[ncell++] = b * GRID_COLS + l;
            if (r != l) cells[ncell++] = b * GRID_COLS + r;
        end
        for (int i = 0; i < ncell; i++) begin
            for (int j = 0; j < int'(grid_fill[cells[i]]); j++) begin
                if (grid_slots[cells[i]][j].id != nb.id &&
                    boxes_touch(nb, grid_slots[cells[i]][j]))
                    expect_result(make_result(1'b1, nb.id,
                        grid_slots[cells[i]][j].id, 1'b0, 1'b0));
            end
        end
        full = 1'b0;
        for (int i = 0; i < ncell; i++) begin
            if (grid_fill[cells[i]] >= CELL_CAPACITY) begin
                full = 1'b1;
            end else begin
                grid_slots[cells[i]][grid_fill[cells[i]]] = nb;
                grid_fill[cells[i]] = grid_fill[cells[i]] + 1'b1;
            end
        end
        expect_result(make_result(1'b0, nb.id, 8'd0, full, 1'b1));
    endtask

    // Driver: presents queued requests at the falling edge, idling at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.data <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycle_count <= cycle_count + 1;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_collisions(req_if.data);
            sent_count <= sent_count + 1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = expected_results.pop_front();
                if (got.pair_valid !== want.pair_valid)
                    report_mismatch($sformatf("pair_valid %b want %b", got.pair_valid,
                                              want.pair_valid));
                if (got.new_id !== want.new_id)
                    report_mismatch($sformatf("new_id %0d want %0d", got.new_id, want.new_id));
                if (got.stored_id !== want.stored_id)
                    report_mismatch($sformatf("stored_id %0d want %0d", got.stored_id,
                                              want.stored_id));
                if (got.cell_full !== want.cell_full)
                    report_mismatch($sformatf("cell_full %b want %b", got.cell_full,
                                              want.cell_full));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b want %b", got.last, want.last));
            end
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic t_request make_insert(int x, int y, int w, int h, int id);
        t_request rq;
        rq.op = OP_INSERT;
        rq.pos_x = x[9:0];
        rq.pos_y = y[9:0];
        rq.width = w[7:0];
        rq.height = h[7:0];
        rq.object_id = id[7:0];
        return rq;
    endfunction

    // A request with every field drawn at random.
    function automatic t_request make_random();
        t_request rq;
        rq.op = 1'($urandom_range(1));
        rq.pos_x = 10'($urandom_range(1023));
        rq.pos_y = 10'($urandom_range(1023));
        rq.width = 8'($urandom_range(255));
        rq.height = 8'($urandom_range(255));
        rq.object_id = 8'($urandom_range(255));
        return rq;
    endfunction

    function automatic t_request make_clear();
        t_request rq;
        rq = make_random();
        rq.op = OP_CLEAR;
        return rq;
    endfunction

    // Waits until every queued request has gone and every result has come back.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (NUM_CELLS + 80) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic idx, input logic [5:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_COLS) cols_reg = val;
        else rows_reg = val;
    endtask

    // A random frame: a clear, then mostly clustered inserts with a small id space, mixed with random requests.
    task automatic queue_frame(input int n);
        int cx;
        int cy;
        queue_req(make_clear());
        cx = $urandom_range(1023);
        cy = $urandom_range(1023);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                queue_req(make_random());
            else if ($urandom_range(3) == 0)
                queue_req(make_insert($urandom_range(1023), $urandom_range(1023),
                    $urandom_range(255), $urandom_range(255), $urandom_range(255)));
            else
                queue_req(make_insert((cx + $urandom_range(80)) % 1024,
                    (cy + $urandom_range(80)) % 1024, $urandom_range(64),
                    $urandom_range(64), $urandom_range(15)));
        end
    endtask

    initial begin
        int phase_settings [4][2];
        phase_settings = '{'{0, 0}, '{75, 0}, '{0, 75}, '{26, 26}};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_COLS;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count = 0;
        sent_count = 0;
        cols_reg = 6'd32;
        rows_reg = 6'd32;
        foreach (grid_fill[c]) grid_fill[c] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (NUM_CELLS + 8) @(posedge i_clk);

        // Directed: extremes, corners, same id, full cell, clamping.
        queue_req(make_insert(0, 0, 0, 0, 0));
        queue_req(make_insert(0, 0, 255, 255, 255));
        queue_req(make_insert(1023, 1023, 255, 255, 1));
        queue_req(make_insert(1023, 0, 0, 255, 2));
        queue_req(make_insert(10, 10, 40, 40, 0));
        queue_req(make_insert(12, 12, 4, 4, 0));
        for (int i = 0; i < 10; i++)
            queue_req(make_insert(5, 5, 8, 8, 10 + i));
        queue_req(make_insert(700, 700, 255, 255, 200));
        queue_req(make_clear());
        queue_req(make_insert(5, 5, 8, 8, 3));
        drain();

        // Grid settings at the extremes, including out-of-range values.
        write_grid(REG_COLS, 6'd0);
        write_grid(REG_ROWS, 6'd63);
        queue_req(make_insert(500, 500, 200, 200, 4));
        queue_req(make_insert(900, 20, 100, 100, 5));
        queue_req(make_insert(500, 600, 30, 30, 6));
        drain();

        // Random frames over four idling phases, each with its own grid size.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_settings[p][0];
            recv_stall_pct = phase_settings[p][1];
            write_grid(REG_COLS, (p == 0) ? 6'd1 : (p == 3 ? 6'd32 : 6'($urandom_range(63))));
            write_grid(REG_ROWS, (p == 1) ? 6'd1 : (p == 3 ? 6'd32 : 6'($urandom_range(63))));
            for (int f = 0; f < 6; f++) begin
                queue_frame($urandom_range(12, 24));
                if (f == 3) begin
                    while (pending_reqs.size() > 0 || req_if.valid) @(posedge i_clk);
                    while (expected_results.size() > 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
